@@ rtl/npr_pkg.sv @@
// ----------------------------------------------------------------------------
// npr_pkg - shared types and constants of the nearest pair region scorer
// Command codes, default parameter values and the control group that
// travels with each item along the pipeline and the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package npr_pkg;

    localparam int MAX_OBSTACLES_DEF = 256;
    localparam int COORD_BITS_DEF    = 16;

    localparam int             WEIGHT_BITS  = 16;
    localparam logic [15:0]    WEIGHT_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_CAND  = 2'd1,
        OP_OBST  = 2'd2,
        OP_EVAL  = 2'd3
    } t_op;

    localparam logic [1:0] SIDE_NONE  = 2'b00;
    localparam logic [1:0] SIDE_LEFT  = 2'b01;
    localparam logic [1:0] SIDE_RIGHT = 2'b11;

    typedef struct packed {
        logic       has_prev;
        logic [7:0] prev_low;
        logic [7:0] prev_high;
        logic [1:0] prev_sgn;
        logic       en;
        logic       use_cross;
        logic [1:0] side;
        logic [8:0] total;
    } t_eval_info;

    typedef struct packed {
        logic       valid;
        t_op        op;
        t_eval_info ev;
    } t_tok_ctl;

endpackage

`default_nettype wire

@@ rtl/npr_in_if.sv @@
// ----------------------------------------------------------------------------
// npr_in_if - command channel
// Valid/ready channel carrying one command item with its coordinates and
// the previous region information.
// ----------------------------------------------------------------------------
`default_nettype none

interface npr_in_if #(
    parameter int COORD_BITS = npr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] x_a;
    logic signed [COORD_BITS-1:0] y_a;
    logic signed [COORD_BITS-1:0] x_b;
    logic signed [COORD_BITS-1:0] y_b;
    logic                         prev_has_region;
    logic [7:0]                   prev_low;
    logic [7:0]                   prev_high;
    logic signed [1:0]            prev_side;

    modport source (
        output valid, command, x_a, y_a, x_b, y_b,
               prev_has_region, prev_low, prev_high, prev_side,
        input  ready
    );

    modport sink (
        input  valid, command, x_a, y_a, x_b, y_b,
               prev_has_region, prev_low, prev_high, prev_side,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/npr_out_if.sv @@
// ----------------------------------------------------------------------------
// npr_out_if - result channel
// Valid/ready channel carrying one evaluation result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface npr_out_if;
    logic               valid;
    logic               ready;
    logic               enabled;
    logic [7:0]         region_low;
    logic [7:0]         region_high;
    logic signed [1:0]  side;
    logic signed [17:0] bonus;
    logic [8:0]         obstacle_total;

    modport source (
        output valid, enabled, region_low, region_high, side, bonus,
               obstacle_total,
        input  ready
    );

    modport sink (
        input  valid, enabled, region_low, region_high, side, bonus,
               obstacle_total,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/nearest_pair_region_scorer_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_pair_region_scorer_unit - two nearest obstacles and region score
// Pipeline: an evaluate item passes the operand stage, multiplier stage,
//   key stage and two cells of the row before its result is offered.
// Throughput: one item per cycle unless stalled; two 17x17 multipliers and
//   each cell take one item per cycle; bubbles squeeze out under backpressure.
// Reset: synchronous; clears pose, axis, candidate, count, cells and valids,
//   bonus weight returns to 256. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_pair_region_scorer_unit #(
    parameter int MAX_OBSTACLES = npr_pkg::MAX_OBSTACLES_DEF,
    parameter int COORD_BITS    = npr_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [npr_pkg::WEIGHT_BITS-1:0] i_cfg_wdata,
    npr_in_if.sink                              i_item,
    npr_out_if.source                           o_result
);

    localparam int OPD_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * OPD_W;
    localparam int KEY_W  = 2 * COORD_BITS + 3;
    localparam int IDX_W  = $clog2(MAX_OBSTACLES);
    localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);

    logic [npr_pkg::WEIGHT_BITS-1:0] r_bonus_weight;

    logic signed [COORD_BITS-1:0] r_pose_x, r_pose_y, r_cand_x, r_cand_y;
    logic signed [OPD_W-1:0]      r_axis_x, r_axis_y;
    logic [CNT_W-1:0]             r_seen;

    logic signed [OPD_W-1:0] xa_e, ya_e, xb_e, yb_e;
    logic signed [OPD_W-1:0] cx_e, cy_e, px_e, py_e;
    logic signed [OPD_W-1:0] dx, dy, rx, ry;
    logic                    axis_zero;
    logic [CNT_W+8:0]        seen_ext;
    logic                    in_fire;

    npr_pkg::t_tok_ctl       n1_ctl, r1_ctl;
    logic signed [OPD_W-1:0] n1_a1, n1_b1, n1_a2, n1_b2;
    logic signed [OPD_W-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic                    n1_sub, r1_sub;
    logic [IDX_W-1:0]        n1_idx, r1_idx;

    npr_pkg::t_tok_ctl        r2_ctl;
    logic signed [PROD_W-1:0] p1, p2, r2_p1, r2_p2;
    logic                     r2_sub;
    logic [IDX_W-1:0]         r2_idx;

    npr_pkg::t_tok_ctl       n3_ctl, r3_ctl;
    logic signed [KEY_W-1:0] sum;
    logic [KEY_W-1:0]        n3_key, r3_key;
    logic [IDX_W-1:0]        r3_idx;

    npr_pkg::t_tok_ctl c0_ctl, c1_ctl;
    logic [KEY_W-1:0]  c0_key, c1_key;
    logic [IDX_W-1:0]  c0_idx, c0_mate, c1_idx, c1_mate;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [IDX_W-1:0]  lo_full, hi_full;
    logic [IDX_W+7:0]  lo_ext, hi_ext;
    logic [7:0]        lo8, hi8;
    logic              match;
    logic [17:0]       mag, bonus;
    npr_pkg::t_eval_info ev_out;

    // handshake chain
    assign rdy5 = !(c1_ctl.valid && (c1_ctl.op == npr_pkg::OP_EVAL)) || o_result.ready;
    assign rdy4 = !c0_ctl.valid || rdy5;
    assign rdy3 = !r3_ctl.valid || rdy4;
    assign rdy2 = !r2_ctl.valid || rdy3;
    assign rdy1 = !r1_ctl.valid || rdy2;

    assign i_item.ready = rdy1;
    assign in_fire      = i_item.valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bonus_weight <= npr_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_bonus_weight <= i_cfg_wdata;
        end
    end

    // operand stage
    assign xa_e = {i_item.x_a[COORD_BITS-1], i_item.x_a};
    assign ya_e = {i_item.y_a[COORD_BITS-1], i_item.y_a};
    assign xb_e = {i_item.x_b[COORD_BITS-1], i_item.x_b};
    assign yb_e = {i_item.y_b[COORD_BITS-1], i_item.y_b};
    assign cx_e = {r_cand_x[COORD_BITS-1], r_cand_x};
    assign cy_e = {r_cand_y[COORD_BITS-1], r_cand_y};
    assign px_e = {r_pose_x[COORD_BITS-1], r_pose_x};
    assign py_e = {r_pose_y[COORD_BITS-1], r_pose_y};
    assign dx   = xa_e - cx_e;
    assign dy   = ya_e - cy_e;
    assign rx   = cx_e - px_e;
    assign ry   = cy_e - py_e;
    assign axis_zero = (r_axis_x == '0) && (r_axis_y == '0);
    assign seen_ext  = {9'b0, r_seen};

    always_comb begin
        n1_ctl = '0;
        n1_a1  = dx;
        n1_b1  = axis_zero ? dx : r_axis_x;
        n1_a2  = dy;
        n1_b2  = axis_zero ? dy : r_axis_y;
        n1_sub = 1'b0;
        n1_idx = r_seen[IDX_W-1:0];
        case (npr_pkg::t_op'(i_item.command))
            npr_pkg::OP_CAND: begin
                n1_ctl.valid = in_fire;
                n1_ctl.op    = npr_pkg::OP_CAND;
            end
            npr_pkg::OP_OBST: begin
                n1_ctl.valid = in_fire && (r_seen < CNT_W'(MAX_OBSTACLES));
                n1_ctl.op    = npr_pkg::OP_OBST;
            end
            npr_pkg::OP_EVAL: begin
                n1_ctl.valid        = in_fire;
                n1_ctl.op           = npr_pkg::OP_EVAL;
                n1_ctl.ev.has_prev  = i_item.prev_has_region;
                n1_ctl.ev.prev_low  = i_item.prev_low;
                n1_ctl.ev.prev_high = i_item.prev_high;
                n1_ctl.ev.prev_sgn  = i_item.prev_side[1] ? npr_pkg::SIDE_RIGHT :
                                      (i_item.prev_side[0] ? npr_pkg::SIDE_LEFT :
                                       npr_pkg::SIDE_NONE);
                n1_ctl.ev.en        = r_seen >= CNT_W'(2);
                n1_ctl.ev.use_cross = !axis_zero;
                n1_ctl.ev.side      = n1_ctl.ev.prev_sgn;
                n1_ctl.ev.total     = seen_ext[8:0];
                n1_a1  = r_axis_x;
                n1_b1  = ry;
                n1_a2  = r_axis_y;
                n1_b2  = rx;
                n1_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_axis_x <= '0;
            r_axis_y <= '0;
            r_cand_x <= '0;
            r_cand_y <= '0;
            r_seen   <= '0;
        end else if (in_fire) begin
            case (npr_pkg::t_op'(i_item.command))
                npr_pkg::OP_FRAME: begin
                    r_pose_x <= i_item.x_a;
                    r_pose_y <= i_item.y_a;
                    r_axis_x <= xb_e - xa_e;
                    r_axis_y <= yb_e - ya_e;
                end
                npr_pkg::OP_CAND: begin
                    r_cand_x <= i_item.x_a;
                    r_cand_y <= i_item.y_a;
                    r_seen   <= '0;
                end
                npr_pkg::OP_OBST: begin
                    if (r_seen < CNT_W'(MAX_OBSTACLES)) begin
                        r_seen <= r_seen + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (rdy1) begin
            r1_ctl <= n1_ctl;
            r1_a1  <= n1_a1;
            r1_b1  <= n1_b1;
            r1_a2  <= n1_a2;
            r1_b2  <= n1_b2;
            r1_sub <= n1_sub;
            r1_idx <= n1_idx;
        end
    end

    // multiplier stage
    assign p1 = r1_a1 * r1_b1;
    assign p2 = r1_a2 * r1_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (rdy2) begin
            r2_ctl <= r1_ctl;
            r2_p1  <= p1;
            r2_p2  <= p2;
            r2_sub <= r1_sub;
            r2_idx <= r1_idx;
        end
    end

    // key stage
    assign sum = r2_sub ? (KEY_W'(r2_p1) - KEY_W'(r2_p2)) : (KEY_W'(r2_p1) + KEY_W'(r2_p2));
    assign n3_key = sum[KEY_W-1] ? (~sum + KEY_W'(1)) : sum;

    always_comb begin
        n3_ctl = r2_ctl;
        if (r2_ctl.ev.use_cross) begin
            n3_ctl.ev.side = sum[KEY_W-1] ? npr_pkg::SIDE_RIGHT :
                             ((sum == '0) ? npr_pkg::SIDE_NONE : npr_pkg::SIDE_LEFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (rdy3) begin
            r3_ctl <= n3_ctl;
            r3_key <= n3_key;
            r3_idx <= r2_idx;
        end
    end

    // row of nearest entries: best, then second
    npr_cell #(.KEY_W(KEY_W), .IDX_W(IDX_W)) u_cell_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy4),
        .i_ctl   (r3_ctl),
        .i_key   (r3_key),
        .i_idx   (r3_idx),
        .i_mate  (r3_idx),
        .o_ctl   (c0_ctl),
        .o_key   (c0_key),
        .o_idx   (c0_idx),
        .o_mate  (c0_mate)
    );

    npr_cell #(.KEY_W(KEY_W), .IDX_W(IDX_W)) u_cell_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy5),
        .i_ctl   (c0_ctl),
        .i_key   (c0_key),
        .i_idx   (c0_idx),
        .i_mate  (c0_mate),
        .o_ctl   (c1_ctl),
        .o_key   (c1_key),
        .o_idx   (c1_idx),
        .o_mate  (c1_mate)
    );

    // result formatting: c1_mate holds the best index, c1_idx the second
    assign ev_out  = c1_ctl.ev;
    assign lo_full = (c1_mate < c1_idx) ? c1_mate : c1_idx;
    assign hi_full = (c1_mate < c1_idx) ? c1_idx : c1_mate;
    assign lo_ext  = {8'b0, lo_full};
    assign hi_ext  = {8'b0, hi_full};
    assign lo8     = lo_ext[7:0];
    assign hi8     = hi_ext[7:0];
    assign match   = ev_out.has_prev && (ev_out.prev_low == lo8) && (ev_out.prev_high == hi8);
    assign mag     = match ? {1'b0, r_bonus_weight, 1'b0} : {2'b00, r_bonus_weight};

    always_comb begin
        bonus = '0;
        if (ev_out.en && (ev_out.prev_sgn != npr_pkg::SIDE_NONE) &&
            (ev_out.side != npr_pkg::SIDE_NONE)) begin
            bonus = (ev_out.side == ev_out.prev_sgn) ? mag : (~mag + 18'd1);
        end
    end

    assign o_result.valid          = c1_ctl.valid && (c1_ctl.op == npr_pkg::OP_EVAL);
    assign o_result.enabled        = ev_out.en;
    assign o_result.region_low     = ev_out.en ? lo8 : 8'd0;
    assign o_result.region_high    = ev_out.en ? hi8 : 8'd0;
    assign o_result.side           = ev_out.en ? ev_out.side : npr_pkg::SIDE_NONE;
    assign o_result.bonus          = bonus;
    assign o_result.obstacle_total = ev_out.total;

endmodule

`default_nettype wire

@@ rtl/npr_cell.sv @@
// ----------------------------------------------------------------------------
// npr_cell - one rank of the nearest obstacle row
// Holds one (key, index) entry. An obstacle with a smaller key displaces the
// entry, which moves on to the next cell; an evaluate picks up the index.
// ----------------------------------------------------------------------------
`default_nettype none

module npr_cell #(
    parameter int KEY_W = 35,
    parameter int IDX_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire npr_pkg::t_tok_ctl i_ctl,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [IDX_W-1:0]  i_mate,
    output npr_pkg::t_tok_ctl      o_ctl,
    output logic      [KEY_W-1:0]  o_key,
    output logic      [IDX_W-1:0]  o_idx,
    output logic      [IDX_W-1:0]  o_mate
);

    logic [KEY_W-1:0]  r_key;
    logic [IDX_W-1:0]  r_idx;
    logic [KEY_W-1:0]  n_key;
    logic [IDX_W-1:0]  n_idx;
    npr_pkg::t_tok_ctl r_out_ctl;
    logic [KEY_W-1:0]  r_out_key;
    logic [IDX_W-1:0]  r_out_idx;
    logic [IDX_W-1:0]  r_out_mate;
    logic [KEY_W-1:0]  n_out_key;
    logic [IDX_W-1:0]  n_out_idx;
    logic [IDX_W-1:0]  n_out_mate;

    always_comb begin
        n_key      = r_key;
        n_idx      = r_idx;
        n_out_key  = i_key;
        n_out_idx  = i_idx;
        n_out_mate = i_mate;
        if (i_ctl.valid) begin
            case (i_ctl.op)
                npr_pkg::OP_CAND: begin
                    n_key = '1;
                    n_idx = '0;
                end
                npr_pkg::OP_OBST: begin
                    // on equal keys the lower index takes the rank
                    if ({i_key, i_idx} < {r_key, r_idx}) begin
                        n_key     = i_key;
                        n_idx     = i_idx;
                        n_out_key = r_key;
                        n_out_idx = r_idx;
                    end
                end
                npr_pkg::OP_EVAL: begin
                    n_out_mate = i_idx;
                    n_out_idx  = r_idx;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '1;
            r_idx     <= '0;
            r_out_ctl <= '0;
        end else if (i_en) begin
            r_key      <= n_key;
            r_idx      <= n_idx;
            r_out_ctl  <= i_ctl;
            r_out_key  <= n_out_key;
            r_out_idx  <= n_out_idx;
            r_out_mate <= n_out_mate;
        end
    end

    assign o_ctl  = r_out_ctl;
    assign o_key  = r_out_key;
    assign o_idx  = r_out_idx;
    assign o_mate = r_out_mate;

endmodule

`default_nettype wire

@@ rtl/npr_checker.sv @@
// ----------------------------------------------------------------------------
// npr_checker - port-level checks of the region scorer
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module npr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_enabled,
    input wire logic [7:0]  i_region_low,
    input wire logic [7:0]  i_region_high,
    input wire logic [1:0]  i_side,
    input wire logic [17:0] i_bonus
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bonus) &&
        $stable(i_region_low) && $stable(i_region_high))
        else $error("result changed while stalled");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_enabled |-> (i_region_low == 8'd0) && (i_region_high == 8'd0) &&
        (i_side == npr_pkg::SIDE_NONE) && (i_bonus == 18'd0))
        else $error("disabled result not cleared");

    a_region_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_enabled |-> i_region_low <= i_region_high)
        else $error("region indices out of order");

    a_no_side_no_bonus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_side == npr_pkg::SIDE_NONE) |-> i_bonus == 18'd0)
        else $error("bonus without a side");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind nearest_pair_region_scorer_unit npr_checker u_npr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_enabled     (o_result.enabled),
    .i_region_low  (o_result.region_low),
    .i_region_high (o_result.region_high),
    .i_side        (o_result.side),
    .i_bonus       (o_result.bonus)
);

`default_nettype wire

@@ dv/tb_nearest_pair_region_scorer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_pair_region_scorer_unit - nearest pair region scorer testbench
// Drives frame, candidate, obstacle and evaluate items through the command
// channel with random gaps. A region predictor tracks pose, axis and the two
// nearest obstacles and queues the expected score of every evaluate item;
// each score on the result channel is compared field by field. The result
// side stalls at random and once holds off long enough to back the block up.
// The stability weight is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_nearest_pair_region_scorer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OBST_LIMIT   = npr_pkg::MAX_OBSTACLES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;

    localparam logic signed [15:0] C_MAX = 16'sh7FFF;
    localparam logic signed [15:0] C_MIN = 16'sh8000;

    typedef struct {
        npr_pkg::t_op       op;
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
        logic               has_prev;
        logic [7:0]         plow;
        logic [7:0]         phigh;
        logic signed [1:0]  pside;
    } t_npr_cmd;

    typedef struct {
        logic              en;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic signed [1:0] side;
        logic signed [17:0] bonus;
        logic [8:0]        total;
    } t_npr_score;

    class region_predictor;
        logic [15:0] weight;
        longint      pose_x, pose_y, axis_x, axis_y, cand_x, cand_y;
        bit [34:0]   best_key, second_key;
        int          best_idx, second_idx, seen;
        t_npr_score  expected_scores[$];
        int          errors;

        function new();
            weight = npr_pkg::WEIGHT_RESET;
            pose_x = 0;
            pose_y = 0;
            axis_x = 0;
            axis_y = 0;
            cand_x = 0;
            cand_y = 0;
            errors = 0;
            clear_search();
        endfunction

        function void clear_search();
            best_key   = '1;
            second_key = '1;
            best_idx   = 0;
            second_idx = 0;
            seen       = 0;
        endfunction

        function void note_item(t_npr_cmd it);
            longint     dx, dy, s, c;
            bit [34:0]  key;
            int         prev, sd, mag;
            t_npr_score sc;
            case (it.op)
                npr_pkg::OP_FRAME: begin
                    pose_x = longint'(it.xa);
                    pose_y = longint'(it.ya);
                    axis_x = longint'(it.xb) - longint'(it.xa);
                    axis_y = longint'(it.yb) - longint'(it.ya);
                end
                npr_pkg::OP_CAND: begin
                    cand_x = longint'(it.xa);
                    cand_y = longint'(it.ya);
                    clear_search();
                end
                npr_pkg::OP_OBST: begin
                    if (seen < OBST_LIMIT) begin
                        dx = longint'(it.xa) - cand_x;
                        dy = longint'(it.ya) - cand_y;
                        if (axis_x == 0 && axis_y == 0) begin
                            s = dx * dx + dy * dy;
                        end else begin
                            s = dx * axis_x + dy * axis_y;
                            if (s < 0) s = -s;
                        end
                        key = s[34:0];
                        if (key < best_key) begin
                            second_key = best_key;
                            second_idx = best_idx;
                            best_key   = key;
                            best_idx   = seen;
                        end else if (key < second_key) begin
                            second_key = key;
                            second_idx = seen;
                        end
                        seen++;
                    end
                end
                default: begin
                    prev = (it.pside > 0) ? 1 : ((it.pside < 0) ? -1 : 0);
                    sc.en = (seen >= 2);
                    sc.lo = '0;
                    sc.hi = '0;
                    sd    = 0;
                    mag   = 0;
                    if (seen >= 2) begin
                        sc.lo = 8'((best_idx < second_idx) ? best_idx : second_idx);
                        sc.hi = 8'((best_idx < second_idx) ? second_idx : best_idx);
                        if (axis_x == 0 && axis_y == 0) begin
                            sd = prev;
                        end else begin
                            c  = axis_x * (cand_y - pose_y) - axis_y * (cand_x - pose_x);
                            sd = (c > 0) ? 1 : ((c < 0) ? -1 : 0);
                        end
                        if (prev != 0 && sd != 0) begin
                            mag = int'(weight);
                            if (it.has_prev && it.plow == sc.lo && it.phigh == sc.hi)
                                mag = mag * 2;
                            if (sd != prev) mag = -mag;
                        end
                    end
                    sc.side  = (sd > 0) ? npr_pkg::SIDE_LEFT :
                               ((sd < 0) ? npr_pkg::SIDE_RIGHT : npr_pkg::SIDE_NONE);
                    sc.bonus = 18'(mag);
                    sc.total = 9'(seen);
                    expected_scores.push_back(sc);
                end
            endcase
        endfunction

        function void cmp_field(string name, logic [17:0] want, logic [17:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h got %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_score(t_npr_score got);
            t_npr_score want;
            if (expected_scores.size() == 0) begin
                errors++;
                $display("%0t ns: score with nothing expected, got total %0d",
                         $time, got.total);
                return;
            end
            want = expected_scores.pop_front();
            cmp_field("enabled", 18'(want.en), 18'(got.en));
            cmp_field("region_low", 18'(want.lo), 18'(got.lo));
            cmp_field("region_high", 18'(want.hi), 18'(got.hi));
            cmp_field("side", 18'(want.side), 18'(got.side));
            cmp_field("bonus", want.bonus, got.bonus);
            cmp_field("obstacle_total", 18'(want.total), 18'(got.total));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    npr_in_if #(.COORD_BITS(npr_pkg::COORD_BITS_DEF)) item_if ();
    npr_out_if result_if ();

    region_predictor predictor;

    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int run_left    = 0;
    bit hold_req    = 0;
    bit hold_done   = 0;

    nearest_pair_region_scorer_unit #(
        .MAX_OBSTACLES(npr_pkg::MAX_OBSTACLES_DEF),
        .COORD_BITS   (npr_pkg::COORD_BITS_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nearest_pair_region_scorer_unit test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? C_MAX : C_MIN;
        if (r < 4) return 16'($urandom_range(0, 16) - 8);
        return 16'($urandom);
    endfunction

    function automatic t_npr_cmd cmd_of(npr_pkg::t_op op, logic signed [15:0] xa = '0,
                                        logic signed [15:0] ya = '0,
                                        logic signed [15:0] xb = '0,
                                        logic signed [15:0] yb = '0);
        t_npr_cmd c;
        c.op       = op;
        c.xa       = xa;
        c.ya       = ya;
        c.xb       = xb;
        c.yb       = yb;
        c.has_prev = 1'b0;
        c.plow     = '0;
        c.phigh    = '0;
        c.pside    = '0;
        return c;
    endfunction

    function automatic t_npr_cmd eval_of(logic has, logic [7:0] lo, logic [7:0] hi,
                                         logic signed [1:0] ps);
        t_npr_cmd c;
        c          = cmd_of(npr_pkg::OP_EVAL);
        c.has_prev = has;
        c.plow     = lo;
        c.phigh    = hi;
        c.pside    = ps;
        return c;
    endfunction

    function automatic t_npr_cmd rnd_frame();
        t_npr_cmd c;
        c = cmd_of(npr_pkg::OP_FRAME, rnd_coord(), rnd_coord());
        if ($urandom_range(0, 3) == 0) begin
            c.xb = c.xa;
            c.yb = c.ya;
        end else begin
            c.xb = rnd_coord();
            c.yb = rnd_coord();
        end
        return c;
    endfunction

    function automatic t_npr_cmd rnd_eval();
        t_npr_cmd c;
        int       lo, hi;
        lo = (predictor.best_idx < predictor.second_idx) ?
             predictor.best_idx : predictor.second_idx;
        hi = (predictor.best_idx < predictor.second_idx) ?
             predictor.second_idx : predictor.best_idx;
        c = eval_of(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 2'($urandom));
        if ($urandom_range(0, 1)) begin
            c.plow  = 8'(lo);
            c.phigh = 8'(hi);
        end
        return c;
    endfunction

    task automatic send_item(t_npr_cmd it);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.command         <= it.op;
        item_if.x_a             <= it.xa;
        item_if.y_a             <= it.ya;
        item_if.x_b             <= it.xb;
        item_if.y_b             <= it.yb;
        item_if.prev_has_region <= it.has_prev;
        item_if.prev_low        <= it.plow;
        item_if.prev_high       <= it.phigh;
        item_if.prev_side       <= it.pside;
        do @(posedge i_clk); while (!item_if.ready);
        predictor.note_item(it);
        items_sent++;
    endtask

    task automatic write_weight(logic [15:0] w);
        item_if.valid <= 1'b0;
        while (predictor.expected_scores.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        predictor.weight = w;
    endtask

    task automatic run_search(int n_obst, int n_eval);
        t_npr_cmd obst;
        if ($urandom_range(0, 2) == 0) send_item(rnd_frame());
        if ($urandom_range(0, 9) != 0)
            send_item(cmd_of(npr_pkg::OP_CAND, rnd_coord(), rnd_coord()));
        obst = cmd_of(npr_pkg::OP_OBST, rnd_coord(), rnd_coord());
        for (int i = 0; i < n_obst; i++) begin
            if ($urandom_range(0, 29) == 0) send_item(rnd_frame());
            if ($urandom_range(0, 39) == 0) send_item(rnd_eval());
            // repeat the last centre now and then to force equal keys
            if (i == 0 || $urandom_range(0, 5) != 0) begin
                obst.xa = rnd_coord();
                obst.ya = rnd_coord();
            end
            send_item(obst);
        end
        for (int e = 0; e < n_eval; e++) send_item(rnd_eval());
    endtask

    // result side: random stalls, clean runs and one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
        end
        if (stall_left > 0) begin
            result_if.ready <= 1'b0;
            stall_left--;
        end else begin
            result_if.ready <= 1'b1;
            if (run_left > 0) run_left--;
            else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 80);
            else stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : score_mon
        t_npr_score got;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.en    = result_if.enabled;
            got.lo    = result_if.region_low;
            got.hi    = result_if.region_high;
            got.side  = result_if.side;
            got.bonus = result_if.bonus;
            got.total = result_if.obstacle_total;
            predictor.check_score(got);
        end
    end

    initial begin
        logic [15:0] weights[5];
        int          n_obst;
        int          target;
        predictor               = new();
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        item_if.valid           = 1'b0;
        item_if.command         = npr_pkg::OP_FRAME;
        item_if.x_a             = '0;
        item_if.y_a             = '0;
        item_if.x_b             = '0;
        item_if.y_b             = '0;
        item_if.prev_has_region = 1'b0;
        item_if.prev_low        = '0;
        item_if.prev_high       = '0;
        item_if.prev_side       = '0;
        result_if.ready         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty and single-obstacle searches report disabled
        send_item(eval_of(1'b0, 8'd0, 8'd0, 2'sb01));
        send_item(cmd_of(npr_pkg::OP_CAND));
        send_item(cmd_of(npr_pkg::OP_OBST, C_MAX, C_MAX));
        send_item(eval_of(1'b1, 8'd0, 8'd0, 2'sb01));
        send_item(cmd_of(npr_pkg::OP_OBST, C_MIN, C_MIN));
        send_item(cmd_of(npr_pkg::OP_OBST, 16'sd0, 16'sd1));
        // zero axis: side follows previous side, matching region doubles
        send_item(eval_of(1'b1, 8'd0, 8'd2, 2'sb01));
        send_item(eval_of(1'b1, 8'd2, 8'd0, 2'sb10));
        // widest axis, equal keys
        send_item(cmd_of(npr_pkg::OP_FRAME, C_MIN, C_MIN, C_MAX, C_MAX));
        send_item(cmd_of(npr_pkg::OP_CAND, C_MAX, C_MIN));
        send_item(cmd_of(npr_pkg::OP_OBST, C_MIN, C_MAX));
        send_item(cmd_of(npr_pkg::OP_OBST, C_MAX, C_MAX));
        send_item(cmd_of(npr_pkg::OP_OBST, 16'sd5, 16'sd5));
        send_item(cmd_of(npr_pkg::OP_OBST, 16'sd5, 16'sd5));
        send_item(eval_of(1'b0, 8'd2, 8'd3, 2'sb11));
        // frame after candidate, candidate on the axis
        send_item(cmd_of(npr_pkg::OP_CAND, 16'sd512, 16'sd0));
        send_item(cmd_of(npr_pkg::OP_OBST, 16'sd3, -16'sd3));
        send_item(cmd_of(npr_pkg::OP_FRAME, 16'sd0, 16'sd0, 16'sd256, 16'sd0));
        send_item(cmd_of(npr_pkg::OP_OBST, -16'sd3, 16'sd3));
        send_item(cmd_of(npr_pkg::OP_OBST, 16'sd700, 16'sd9));
        send_item(eval_of(1'b1, 8'd0, 8'd1, 2'sb01));
        send_item(eval_of(1'b1, 8'd0, 8'd1, 2'sb00));

        weights[0] = 16'hFFFF;
        weights[1] = 16'h0000;
        weights[2] = 16'($urandom);
        weights[3] = 16'h0001;
        weights[4] = 16'($urandom);
        for (int p = 0; p < 5; p++) begin
            write_weight(weights[p]);
            if (p == 1) hold_req = 1'b1;
            target = items_sent + 50;
            while (items_sent < target) begin
                n_obst = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) :
                                                      $urandom_range(7, 30);
                run_search(n_obst, $urandom_range(1, 2));
            end
            // overfill the search so the count saturates
            if (p == 2) run_search(OBST_LIMIT + 6, 2);
        end

        item_if.valid <= 1'b0;
        while (predictor.expected_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predictor.errors == 0 && predictor.expected_scores.size() == 0)
            $display("nearest_pair_region_scorer_unit test passed");
        else
            $display("nearest_pair_region_scorer_unit test failed");
        $finish;
    end
endmodule
